// File: hw/rtl/lbsp_pkg.sv
// Shared constants and types for the shared-pin LED blinker.
package lbsp_pkg;

    localparam int PERIOD_W   = 16;
    localparam int DEBOUNCE_W = 11;
    localparam int PATTERN_W  = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [PERIOD_W-1:0]   BLINK_PERIOD_RST    = PERIOD_W'(500);
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RELOAD_RST = DEBOUNCE_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_RELOAD = 1'b1;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SET  = 1'b1;

    localparam logic [PATTERN_W-1:0] PAT_OFF  = 3'd0;
    localparam logic [PATTERN_W-1:0] PAT_ON   = 3'd1;
    localparam logic [PATTERN_W-1:0] PAT_RED  = 3'd2;
    localparam logic [PATTERN_W-1:0] PAT_BLUE = 3'd3;
    localparam logic [PATTERN_W-1:0] PAT_BOTH = 3'd4;
    localparam logic [PATTERN_W-1:0] PAT_ALT  = 3'd5;

    typedef struct packed {
        logic red_on;
        logic blue_on;
        logic sense_window;
        logic button_pressed;
    } t_result;

endpackage

// File: hw/rtl/lbsp_core.sv
// Blink phase counter, LED pattern decode and button debounce state.
module lbsp_core
    import lbsp_pkg::*;
#(
    parameter logic [DEBOUNCE_W-1:0] DEBOUNCE_INIT = DEBOUNCE_RELOAD_RST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic                  i_operation,
    input  logic [PATTERN_W-1:0]  i_pattern,
    input  logic                  i_leds_enabled,
    input  logic                  i_button_level,
    input  logic [PERIOD_W-1:0]   i_blink_period,
    input  logic [DEBOUNCE_W-1:0] i_debounce_reload,
    output t_result               o_result,
    output logic                  o_pressed_flag
);

    logic [PERIOD_W-1:0]   r_tick_count, n_tick_count, tick_inc;
    logic                  r_phase, n_phase;
    logic [DEBOUNCE_W-1:0] r_debounce_left, n_debounce_left, debounce_dec;
    logic                  r_pressed, n_pressed;
    logic                  r_red_lit, n_red_lit;
    logic                  r_blue_lit, n_blue_lit;
    logic                  sensed;

    always_comb begin
        n_tick_count    = r_tick_count;
        n_phase         = r_phase;
        n_debounce_left = r_debounce_left;
        n_pressed       = r_pressed;
        n_red_lit       = r_red_lit;
        n_blue_lit      = r_blue_lit;
        sensed          = 1'b0;
        tick_inc        = r_tick_count + PERIOD_W'(1);
        debounce_dec    = r_debounce_left - DEBOUNCE_W'(1);

        if (i_operation == OP_SET) begin
            if (!i_leds_enabled || i_pattern == PAT_OFF) begin
                n_red_lit  = 1'b0;
                n_blue_lit = 1'b0;
            end else begin
                case (i_pattern)
                    PAT_RED: begin
                        n_red_lit  = 1'b1;
                        n_blue_lit = 1'b0;
                    end
                    PAT_BLUE: begin
                        n_red_lit  = 1'b0;
                        n_blue_lit = 1'b1;
                    end
                    PAT_BOTH: begin
                        n_red_lit  = 1'b1;
                        n_blue_lit = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end else begin
            n_tick_count = tick_inc;
            if (tick_inc >= i_blink_period) begin
                n_tick_count = '0;
                n_phase      = ~r_phase;
                if (r_pressed || i_pattern == PAT_ON) begin
                    n_red_lit  = 1'b1;
                    n_blue_lit = 1'b1;
                end else if (!i_leds_enabled || i_pattern == PAT_OFF) begin
                    n_red_lit  = 1'b0;
                    n_blue_lit = 1'b0;
                end else begin
                    case (i_pattern)
                        PAT_ALT: begin
                            n_red_lit  = n_phase;
                            n_blue_lit = ~n_phase;
                            sensed     = n_phase;
                        end
                        PAT_BLUE: begin
                            n_red_lit  = 1'b0;
                            n_blue_lit = ~n_phase;
                            sensed     = 1'b1;
                        end
                        PAT_RED: begin
                            n_red_lit  = ~n_phase;
                            n_blue_lit = 1'b0;
                            sensed     = ~n_phase;
                        end
                        PAT_BOTH: begin
                            n_red_lit  = ~n_phase;
                            n_blue_lit = ~n_phase;
                            sensed     = ~n_phase;
                        end
                        default: begin
                        end
                    endcase
                end
                if (sensed) begin
                    if (!i_button_level) begin
                        n_debounce_left = debounce_dec;
                        if (debounce_dec == '0) begin
                            n_pressed       = 1'b1;
                            n_debounce_left = i_debounce_reload;
                        end
                    end else begin
                        n_debounce_left = i_debounce_reload;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count    <= '0;
            r_phase         <= 1'b0;
            r_debounce_left <= DEBOUNCE_INIT;
            r_pressed       <= 1'b0;
            r_red_lit       <= 1'b0;
            r_blue_lit      <= 1'b0;
        end else if (i_step) begin
            r_tick_count    <= n_tick_count;
            r_phase         <= n_phase;
            r_debounce_left <= n_debounce_left;
            r_pressed       <= n_pressed;
            r_red_lit       <= n_red_lit;
            r_blue_lit      <= n_blue_lit;
        end
    end

    assign o_result.red_on         = n_red_lit;
    assign o_result.blue_on        = n_blue_lit;
    assign o_result.sense_window   = sensed;
    assign o_result.button_pressed = n_pressed;
    assign o_pressed_flag          = r_pressed;

endmodule

// File: hw/rtl/led_blinker_shared_pin_button.sv
// Red/blue LED blinker with a push button sensed on the red LED's pin.
// Each accepted beat (a millisecond tick or a steady-pattern set) is handled in
// the cycle it is accepted and its result lands in one output register, so the
// block takes one beat per cycle whenever the output is empty or being taken.
// The debounce counter reloads whenever the pin reads high in a sense window,
// and the sticky pressed flag is cleared only by reset. Configure blink_period
// (index 0) and debounce_reload (index 1) while idle.
module led_blinker_shared_pin_button
    import lbsp_pkg::*;
#(
    parameter logic [PERIOD_W-1:0]   BLINK_PERIOD_INIT    = BLINK_PERIOD_RST,
    parameter logic [DEBOUNCE_W-1:0] DEBOUNCE_RELOAD_INIT = DEBOUNCE_RELOAD_RST
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_operation,
    input  logic [PATTERN_W-1:0]  i_pattern,
    input  logic                  i_leds_enabled,
    input  logic                  i_button_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_red_on,
    output logic                  o_blue_on,
    output logic                  o_sense_window,
    output logic                  o_button_pressed
);

    logic [PERIOD_W-1:0]   r_blink_period;
    logic [DEBOUNCE_W-1:0] r_debounce_reload;
    logic                  r_out_valid;
    t_result               r_result;
    t_result               step_result;
    logic                  pressed_flag;
    logic                  in_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_period    <= BLINK_PERIOD_INIT;
            r_debounce_reload <= DEBOUNCE_RELOAD_INIT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_BLINK_PERIOD:    r_blink_period    <= i_cfg_data;
                CFG_DEBOUNCE_RELOAD: r_debounce_reload <= i_cfg_data[DEBOUNCE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    lbsp_core #(
        .DEBOUNCE_INIT (DEBOUNCE_RELOAD_INIT)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (in_accept),
        .i_operation       (i_operation),
        .i_pattern         (i_pattern),
        .i_leds_enabled    (i_leds_enabled),
        .i_button_level    (i_button_level),
        .i_blink_period    (r_blink_period),
        .i_debounce_reload (r_debounce_reload),
        .o_result          (step_result),
        .o_pressed_flag    (pressed_flag)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_red_on         = r_result.red_on;
    assign o_blue_on        = r_result.blue_on;
    assign o_sense_window   = r_result.sense_window;
    assign o_button_pressed = r_result.button_pressed;

    a_set_never_senses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_operation == OP_SET) |=> (o_out_valid && !o_sense_window))
        else $error("steady-pattern beat reported a sense window");

    a_pressed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pressed_flag |=> pressed_flag)
        else $error("pressed flag cleared without reset");

    a_result_tracks_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_button_pressed == pressed_flag))
        else $error("reported pressed flag differs from core state");

endmodule
